// ===== src/hfq_pkg.sv =====
// Package for the hashed FIFO ready queue: opcodes, status codes, FNV-1a constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hfq_pkg;
  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_REM = 2'd2,
    OP_HAS = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_OVER  = 3'd1,
    ST_FULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_NONE  = 3'd4
  } status_t;

  localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
  localparam logic [31:0] FNV_MULT  = 32'h01000193;
  localparam logic [6:0]  THRESHOLD_RESET = 7'd48;
endpackage
`default_nettype wire

// ===== src/hfq_if.sv =====
// Valid/ready channel interface with a generic payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface hfq_if #(parameter int W = 8) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/hashed_fifo_ready_queue.sv =====
// Top level of the hashed FIFO ready queue: sequencer and slot memories.
// Depends on hfq_pkg, hfq_if and hfq_hash.
//
//  channel  dir  payload
//  req      in   {operation[49:48], id[47:32], handle[31:0]}
//  rsp      out  {status[58:56], found[55], result_id[54:39], result_handle[38:7],
//                 entry_count[6:0]}
//
// Sequence: the id is hashed, then each probe issues the slot read and checks the
// registered data, up to CAPACITY probes, and the output register is loaded.
// Remove adds an unlink step. Dequeue skips the hash and the probes: it reads the
// head slot and takes it through the unlink path; on an empty queue it goes
// straight to the output register.
// Reset clears head, tail and count; the occupied map is then cleared one slot
// per cycle while req.ready stays low.
// A result waiting in the output register stalls the sequencer only when the
// next result is ready to load; a new request is accepted once it is idle.
`timescale 1ns / 1ps
`default_nettype none
module hashed_fifo_ready_queue
  import hfq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  hfq_if.sink             req,
  hfq_if.source           rsp
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = (CW > 7) ? CW : 7;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PROBE, S_CHECK, S_RD, S_UNLINK, S_LINK2, S_DONE
  } state_t;

  state_t          state;
  logic [6:0]      threshold;
  logic [1:0]      op;
  logic [15:0]     id;
  logic [31:0]     handle;
  logic [AW-1:0]   head, tail, cur, clr;
  logic [CW-1:0]   count, probes;

  // slot memories
  logic          occ_mem [CAPACITY];
  logic [15:0]   key_mem [CAPACITY];
  logic [31:0]   ref_mem [CAPACITY];
  logic [AW-1:0] fwd_mem [CAPACITY];
  logic [AW-1:0] bwd_mem [CAPACITY];
  logic          occ_q;
  logic [15:0]   key_q;
  logic [31:0]   ref_q;
  logic [AW-1:0] fwd_q, bwd_q;

  logic          hash_start, hash_done;
  logic [AW-1:0] hash_slot;

  logic [2:0]  r_status;
  logic        r_found;
  logic [15:0] r_id;
  logic [31:0] r_handle;

  // output register
  logic [2:0]  o_status;
  logic        o_found;
  logic [15:0] o_id;
  logic [31:0] o_handle;
  logic [6:0]  o_count;
  logic        out_valid;
  logic        load_out;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = {o_status, o_found, o_id, o_handle, o_count};
  assign hash_start = req.valid && req.ready;
  assign load_out  = (state == S_DONE) && (!out_valid || rsp.ready);

  hfq_hash #(.CAPACITY(CAPACITY), .AW(AW)) u_hash (
    .clk(clk), .rst(rst), .start(hash_start), .id(req.data[47:32]),
    .done(hash_done), .slot(hash_slot)
  );

  // registered reads at cur
  always_ff @(posedge clk) begin
    occ_q <= occ_mem[cur];
    key_q <= key_mem[cur];
    ref_q <= ref_mem[cur];
    fwd_q <= fwd_mem[cur];
    bwd_q <= bwd_mem[cur];
  end

  logic [AW-1:0] nxt;
  assign nxt = (cur == AW'(CAPACITY - 1)) ? '0 : cur + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      threshold <= THRESHOLD_RESET;
      head <= '0;
      tail <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      // load the finished result, or drop the one just taken
      if (load_out) begin
        out_valid <= 1'b1;
        o_status  <= r_status;
        o_found   <= r_found;
        o_id      <= r_id;
        o_handle  <= r_handle;
        o_count   <= 7'(count);
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          // clear one occupied bit per cycle after reset
          occ_mem[clr] <= 1'b0;
          clr <= clr + AW'(1);
          if (clr == AW'(CAPACITY - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (hash_start) begin
            op     <= req.data[49:48];
            id     <= req.data[47:32];
            handle <= req.data[31:0];
            r_status <= ST_OK;
            r_found  <= 1'b0;
            r_id     <= '0;
            r_handle <= '0;
            probes   <= '0;
            if (op_t'(req.data[49:48]) == OP_DEQ) begin
              if (count == '0) begin
                r_status <= ST_EMPTY;
                state <= S_DONE;
              end else begin
                cur <= head;
                state <= S_RD;
              end
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            cur <= hash_slot;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          // memory read of cur is in flight
          if (probes == CW'(CAPACITY)) begin
            r_status <= (op_t'(op) == OP_ENQ) ? ST_FULL : ST_NONE;
            state <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (op_t'(op) == OP_ENQ) begin
            if (!occ_q) begin
              occ_mem[cur] <= 1'b1;
              key_mem[cur] <= id;
              ref_mem[cur] <= handle;
              if (count == '0) head <= cur;
              else begin
                fwd_mem[tail] <= cur;
                bwd_mem[cur]  <= tail;
              end
              tail <= cur;
              count <= count + CW'(1);
              r_status <= ((TW'(count) + TW'(1)) > TW'(threshold)) ? ST_OVER : ST_OK;
              state <= S_DONE;
            end else begin
              cur <= nxt;
              probes <= probes + CW'(1);
              state <= S_PROBE;
            end
          end else if (occ_q && key_q == id) begin
            r_found <= 1'b1;
            if (op_t'(op) == OP_REM) begin
              r_id <= key_q;
              r_handle <= ref_q;
              state <= S_UNLINK;
            end else state <= S_DONE;
          end else begin
            cur <= nxt;
            probes <= probes + CW'(1);
            state <= S_PROBE;
          end
        end
        S_RD: begin
          r_found <= 1'b1;
          op <= OP_REM;
          id <= '0;
          // dequeue: head is occupied; take it via the unlink path
          state <= S_LINK2;
        end
        S_LINK2: begin
          r_id <= key_q;
          r_handle <= ref_q;
          state <= S_UNLINK;
        end
        S_UNLINK: begin
          if (cur == head && cur == tail) begin
            head <= '0;
            tail <= '0;
          end else if (cur == head) head <= fwd_q;
          else if (cur == tail) tail <= bwd_q;
          else begin
            fwd_mem[bwd_q] <= fwd_q;
            bwd_mem[fwd_q] <= bwd_q;
          end
          occ_mem[cur] <= 1'b0;
          count <= count - CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_UNLINK) |=> $past(count) == count + CW'(1))
    else $error("unlink did not decrement");
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
    else $error("response changed while stalled");
  assert property (@(posedge clk) disable iff (rst) (state == S_CLEAR) |-> !req.ready)
    else $error("accept during clear");
endmodule
`default_nettype wire

// ===== src/hfq_hash.sv =====
// FNV-1a hash of a 16-bit id, one byte per cycle, folded and reduced to a slot index.
// Depends on hfq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hfq_hash
  import hfq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [15:0]   id,
  output logic               done,
  output logic [AW-1:0]      slot
);
  // Reciprocal for the slot reduction; exact for any 16-bit fold and CAPACITY <= 4096.
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(CAPACITY) + 64'd1);

  logic [31:0] h;
  logic [15:0] idr;
  logic [2:0]  step;
  logic        busy;
  logic [7:0]  byte_v;
  logic [31:0] mixed;
  logic [15:0] fold;
  logic [47:0] prod;
  logic [15:0] quot;
  logic [31:0] qmul;

  assign byte_v = (step == 3'd0) ? idr[7:0] : (step == 3'd1) ? idr[15:8] : 8'h00;
  assign mixed  = (h ^ {24'd0, byte_v}) * FNV_MULT;
  assign fold   = h[31:16] ^ h[15:0];
  assign prod   = 48'(fold) * 48'(RECIP);
  assign qmul   = 32'(quot) * 32'(CAPACITY);
  assign slot   = fold[AW-1:0] - qmul[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        h    <= FNV_BASIS;
        idr  <= id;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd4) begin
          // hold the quotient; the slot is the remainder of the fold
          quot <= prod[47:32];
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          h <= mixed;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/hashed_fifo_ready_queue_test.sv =====
// Testbench for the hashed FIFO ready queue: drives enqueue, dequeue, remove and
// contains requests and checks every response against an in-bench queue predictor.
// Depends on hfq_pkg, hfq_if and hashed_fifo_ready_queue.
`timescale 1ns / 1ps
module hashed_fifo_ready_queue_test;
  import hfq_pkg::*;

  localparam int SLOTS = 64;

  typedef struct packed {
    status_t     status;
    logic        found;
    logic [15:0] rid;
    logic [31:0] rhandle;
    logic [6:0]  count;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  hfq_if #(.W(50)) req (.clk(clk));
  hfq_if #(.W(59)) rsp (.clk(clk));

  hashed_fifo_ready_queue #(.CAPACITY(SLOTS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .rsp(rsp.source)
  );

  // Predictor state: a mirror of the slot table, its queue links and the threshold.
  logic        occ [SLOTS];
  logic [15:0] key [SLOTS];
  logic [31:0] handle_mem [SLOTS];
  logic [5:0]  fwd [SLOTS];
  logic [5:0]  bwd [SLOTS];
  logic [5:0]  head, tail;
  logic [6:0]  held, threshold;

  answer_t pending_answers[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit shadow_ids = 0;        // steer ids to a small colliding set
  logic [15:0] live_ids[$];   // ids currently queued, for hit-heavy traffic

  // FNV-1a over the id zero-extended to four bytes, low first, folded and masked to the table.
  function automatic logic [5:0] home_of(logic [15:0] id);
    logic [31:0] h;
    logic [31:0] word;
    h = FNV_BASIS;
    word = {16'h0, id};
    for (int b = 0; b < 4; b++) begin
      h = h ^ ((word >> (8 * b)) & 32'hFF);
      h = h * FNV_MULT;
    end
    h = ((h >> 16) ^ h) & 32'hFFFF;
    return h[5:0];
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) occ[i] = 1'b0;
    head = '0;
    tail = '0;
    held = '0;
    threshold = THRESHOLD_RESET;
    live_ids.delete();
  endfunction

  function automatic void forget_live(logic [15:0] id);
    foreach (live_ids[i])
      if (live_ids[i] == id) begin
        live_ids.delete(i);
        return;
      end
  endfunction

  // Take a slot out of the queue order; a middle slot is spliced out.
  function automatic void unlink(logic [5:0] s);
    if (s == head && s == tail) begin
      head = '0;
      tail = '0;
    end else if (s == head) begin
      head = fwd[s];
    end else if (s == tail) begin
      tail = bwd[s];
    end else begin
      fwd[bwd[s]] = fwd[s];
      bwd[fwd[s]] = bwd[s];
    end
    occ[s] = 1'b0;
    held = held - 1;
    forget_live(key[s]);
  endfunction

  function automatic answer_t predict_queue_op(op_t op, logic [15:0] id, logic [31:0] hnd);
    answer_t a;
    logic [5:0] s;
    int n;
    a = '{status: ST_OK, found: 1'b0, rid: '0, rhandle: '0, count: '0};
    case (op)
      OP_ENQ: begin
        s = home_of(id);
        n = 0;
        while (n < SLOTS && occ[s]) begin
          s = s + 1;
          n++;
        end
        if (n == SLOTS) begin
          a.status = ST_FULL;
        end else begin
          occ[s] = 1'b1;
          key[s] = id;
          handle_mem[s] = hnd;
          if (held == 0) begin
            head = s;
          end else begin
            fwd[tail] = s;
            bwd[s] = tail;
          end
          tail = s;
          held = held + 1;
          live_ids.push_back(id);
          a.status = (held > threshold) ? ST_OVER : ST_OK;
        end
      end
      OP_DEQ: begin
        if (held == 0) begin
          a.status = ST_EMPTY;
        end else begin
          s = head;
          a.found = 1'b1;
          a.rid = key[s];
          a.rhandle = handle_mem[s];
          unlink(s);
        end
      end
      default: begin
        // Probe every slot from home, skipping free ones; first match wins.
        s = home_of(id);
        n = 0;
        while (n < SLOTS && !(occ[s] && key[s] == id)) begin
          s = s + 1;
          n++;
        end
        if (n == SLOTS) begin
          a.status = ST_NONE;
        end else begin
          a.found = 1'b1;
          if (op == OP_REM) begin
            a.rid = key[s];
            a.rhandle = handle_mem[s];
            unlink(s);
          end
        end
      end
    endcase
    a.count = held;
    return a;
  endfunction

  // Send one request: random idle before it, hold valid until accepted.
  task automatic send_request(op_t op, logic [15:0] id, logic [31:0] hnd);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= {op, id, hnd};
    do @(posedge clk); while (!req.ready);
    pending_answers.push_back(predict_queue_op(op, id, hnd));
  endtask

  // Receiver: stall at random, compare each accepted response with the oldest prediction.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        answer_t got, want;
        got = answer_t'(rsp.data);
        if (pending_answers.size() == 0) begin
          $error("response with no request outstanding: %h", rsp.data);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (got.status != want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            errors++;
          end
          if (got.found != want.found) begin
            $error("found expected %0d got %0d", want.found, got.found);
            errors++;
          end
          if (got.rid != want.rid) begin
            $error("result_id expected %h got %h", want.rid, got.rid);
            errors++;
          end
          if (got.rhandle != want.rhandle) begin
            $error("result_handle expected %h got %h", want.rhandle, got.rhandle);
            errors++;
          end
          if (got.count != want.count) begin
            $error("entry_count expected %0d got %0d", want.count, got.count);
            errors++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Drop valid, wait for all responses, then for the sequencer to settle.
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [6:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold = value;
  endtask

  function automatic logic [15:0] pick_id();
    if (live_ids.size() != 0 && $urandom_range(1))
      return live_ids[$urandom_range(live_ids.size() - 1)];
    if (shadow_ids) return 16'($urandom_range(15));
    return 16'($urandom);
  endfunction

  // Extremes of the fields, empty and missing cases, contains hit, middle removal.
  task automatic test_directed();
    send_request(OP_DEQ, 16'h0000, 32'h0);
    send_request(OP_HAS, 16'hFFFF, 32'h0);
    send_request(OP_REM, 16'h1234, 32'h0);
    send_request(OP_ENQ, 16'h0000, 32'h0000_0000);
    send_request(OP_ENQ, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(OP_ENQ, 16'hA5A5, 32'h5A5A_A5A5);
    send_request(OP_ENQ, 16'h5A5A, 32'hA5A5_5A5A);
    send_request(OP_ENQ, 16'hFFFF, 32'h1111_2222);   // duplicate id
    send_request(OP_HAS, 16'hA5A5, 32'hDEAD_BEEF);
    send_request(OP_REM, 16'hA5A5, 32'h0);           // middle entry
    send_request(OP_REM, 16'h5A5A, 32'h0);
    send_request(OP_REM, 16'hFFFF, 32'h0);           // first in probe order
    send_request(OP_HAS, 16'hFFFF, 32'h0);
    send_request(OP_DEQ, 16'hBEEF, 32'h0);
    send_request(OP_DEQ, 16'h0000, 32'h0);
    send_request(OP_DEQ, 16'h0000, 32'h0);
  endtask

  // Fill the table to full, overflow it, then empty it through dequeue.
  task automatic test_fill_and_overflow();
    write_threshold(7'd0);
    for (int i = 0; i < SLOTS + 2; i++) send_request(OP_ENQ, 16'($urandom), $urandom);
    send_request(OP_REM, 16'($urandom), 32'h0);
    send_request(OP_ENQ, 16'($urandom), $urandom);
    for (int i = 0; i < SLOTS + 1; i++) send_request(OP_DEQ, 16'($urandom), 32'h0);
    write_threshold(7'd64);
  endtask

  task automatic test_random(int items);
    for (int i = 0; i < items; i++) begin
      int r;
      op_t op;
      r = $urandom_range(99);
      if (held > 56) op = (r < 20) ? OP_ENQ : (r < 60) ? OP_REM : (r < 80) ? OP_DEQ : OP_HAS;
      else op = (r < 45) ? OP_ENQ : (r < 60) ? OP_DEQ : (r < 82) ? OP_REM : OP_HAS;
      send_request(op, pick_id(), $urandom);
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    clear_table();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_overflow();
    // Each phase: a threshold setting and an idling pattern.
    write_threshold(7'd10);
    test_random(150);
    send_idle_pct = 78;
    write_threshold(7'd48);
    shadow_ids = 1;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 78;
    write_threshold(7'd1);
    test_random(150);
    send_idle_pct = 28;
    recv_stall_pct = 28;
    write_threshold(7'd127);
    shadow_ids = 0;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_threshold(7'd32);
    test_random(100);
    drain();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end
endmodule
